>>> rtl/core/mbrtu_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus RTU poll-and-check block.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package mbrtu_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEVICE_ADDRESS   = 2'd0;
    localparam logic [1:0] REG_REGISTER_ADDRESS = 2'd1;
    localparam logic [1:0] REG_LINE_VOLTAGE     = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  DEVICE_ADDRESS_RST   = 8'h01;
    localparam logic [15:0] REGISTER_ADDRESS_RST = 16'h0049;
    localparam logic [8:0]  LINE_VOLTAGE_RST     = 9'd220;

    // Modbus framing constants.
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  QUANTITY_HI       = 8'h00;
    localparam logic [7:0]  QUANTITY_LO       = 8'h01;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;

    // Operation codes of an input item.
    localparam logic OP_RX_BYTE = 1'b0;
    localparam logic OP_POLL    = 1'b1;

    // Response frame byte positions.
    localparam logic [3:0] POS_FIRST     = 4'd0;
    localparam logic [3:0] POS_VALUE_LO  = 4'd3;
    localparam logic [3:0] POS_LAST_DATA = 4'd6;
    localparam logic [3:0] POS_CRC_LO    = 4'd7;
    localparam logic [3:0] POS_CRC_HI    = 4'd8;

    // Request byte positions.
    localparam logic [2:0] TX_LAST_DATA = 3'd5;
    localparam logic [2:0] TX_LAST      = 3'd7;

    // What the deframer reports when the ninth byte of a frame arrives.
    typedef struct packed {
        logic        id_ok;
        logic        crc_ok;
        logic [31:0] current_raw;
        logic [40:0] power_estimate;
    } frame_report_t;

    // One byte of the reflected CRC-16 used by Modbus RTU.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        int          k;
        c = crc_in ^ {8'h00, data};
        for (k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mbrtu_tx_seq.sv
// Read-request sequencer: produces the eight request bytes, one per step, with a running CRC.
// Depends on mbrtu_pkg.
`default_nettype none

module mbrtu_tx_seq (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  device_address,
    input  wire logic [15:0] register_address,
    output logic [7:0]       tx_byte,
    output logic             tx_last
);

    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_base;

    // The CRC restarts with the first byte of every request.
    assign crc_base = (count_reg == 3'd0) ? mbrtu_pkg::CRC_INIT : crc_reg;

    always_comb
    begin
        case (count_reg)
            3'd0: tx_byte = device_address;
            3'd1: tx_byte = mbrtu_pkg::FUNC_READ_HOLDING;
            3'd2: tx_byte = register_address[15:8];
            3'd3: tx_byte = register_address[7:0];
            3'd4: tx_byte = mbrtu_pkg::QUANTITY_HI;
            3'd5: tx_byte = mbrtu_pkg::QUANTITY_LO;
            3'd6: tx_byte = crc_reg[7:0];
            default: tx_byte = crc_reg[15:8];
        endcase
    end

    assign tx_last = (count_reg == mbrtu_pkg::TX_LAST);

    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        if (step)
        begin
            count_next = count_reg + 3'd1;
            if (count_reg <= mbrtu_pkg::TX_LAST_DATA)
                crc_next = mbrtu_pkg::crc16_byte(crc_base, tx_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
            crc_reg   <= mbrtu_pkg::CRC_INIT;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mbrtu_rx_deframer.sv
// Nine-byte response deframer: running CRC, id check, big-endian value capture and power product.
// Depends on mbrtu_pkg.
`default_nettype none

module mbrtu_rx_deframer (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     step,
    input  wire logic [7:0]               rx_byte,
    input  wire logic [7:0]               device_address,
    input  wire logic [8:0]               line_voltage,
    output logic                          at_last,
    output mbrtu_pkg::frame_report_t      report
);

    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [31:0] value_reg;
    logic [31:0] value_next;
    logic        addr_match_reg;
    logic        addr_match_next;
    logic        crc_lo_match_reg;
    logic        crc_lo_match_next;
    logic [15:0] crc_base;
    logic [31:0] value_base;

    assign at_last = (pos_reg >= mbrtu_pkg::POS_CRC_HI);

    // Byte 0 starts a fresh frame: CRC and value shifter begin from their initial values.
    assign crc_base   = (pos_reg == mbrtu_pkg::POS_FIRST) ? mbrtu_pkg::CRC_INIT : crc_reg;
    assign value_base = (pos_reg == mbrtu_pkg::POS_FIRST) ? 32'd0 : value_reg;

    always_comb
    begin
        pos_next          = pos_reg;
        crc_next          = crc_reg;
        value_next        = value_reg;
        addr_match_next   = addr_match_reg;
        crc_lo_match_next = crc_lo_match_reg;
        if (step)
        begin
            if (pos_reg == mbrtu_pkg::POS_FIRST)
            begin
                addr_match_next   = (rx_byte == device_address);
                crc_lo_match_next = 1'b0;
            end
            if (pos_reg <= mbrtu_pkg::POS_LAST_DATA)
            begin
                crc_next   = mbrtu_pkg::crc16_byte(crc_base, rx_byte);
                value_next = value_base;
                if (pos_reg >= mbrtu_pkg::POS_VALUE_LO)
                    value_next = {value_base[23:0], rx_byte};
                pos_next = pos_reg + 4'd1;
            end
            else if (pos_reg == mbrtu_pkg::POS_CRC_LO)
            begin
                crc_lo_match_next = (rx_byte == crc_reg[7:0]);
                pos_next          = mbrtu_pkg::POS_CRC_HI;
            end
            else
            begin
                pos_next = mbrtu_pkg::POS_FIRST;
                crc_next = mbrtu_pkg::CRC_INIT;
            end
        end
    end

    always_comb
    begin
        report.id_ok          = addr_match_reg;
        report.crc_ok         = crc_lo_match_reg && (rx_byte == crc_reg[15:8]);
        report.current_raw    = value_reg;
        report.power_estimate = {9'd0, value_reg} * {32'd0, line_voltage};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= mbrtu_pkg::POS_FIRST;
            crc_reg          <= mbrtu_pkg::CRC_INIT;
            value_reg        <= 32'd0;
            addr_match_reg   <= 1'b0;
            crc_lo_match_reg <= 1'b0;
        end
        else
        begin
            pos_reg          <= pos_next;
            crc_reg          <= crc_next;
            value_reg        <= value_next;
            addr_match_reg   <= addr_match_next;
            crc_lo_match_reg <= crc_lo_match_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/modbus_rtu_meter_poll_and_check.sv
// Modbus RTU master for one meter register: input stage, configuration registers, result register.
// Instantiates mbrtu_tx_seq and mbrtu_rx_deframer; depends on mbrtu_pkg.
//
// Usage. Items arrive on the input channel (in_valid / in_stall, operation, rx_byte). An item
// with operation = 1 is a poll: it yields eight result transfers carrying the read request
// (device id, function 3, register address, quantity 1, CRC-16 low then high byte), with
// tx_last on the eighth. An item with operation = 0 is a byte received from the meter; the
// ninth byte of each response frame yields one result transfer with frame_valid, id_ok,
// crc_ok, current_raw and power_estimate = current_raw * line_voltage. Other bytes yield none.
// An accepted transfer is stored in the input register, and any results it yields are loaded
// into the output register, from which they are transferred. Received bytes are taken one per
// cycle unless a poll holds the input register or a frame's ninth byte waits for a free
// output register. A poll holds the input register until its eighth request byte has gone into
// the output register. While the downstream side asserts out_stall the output register holds
// its transfer, and once the input register is also occupied by work that needs the output,
// in_stall is raised. Reset clears the pipeline, the response deframer and the request
// sequencer, and restores the configuration registers to device 1, register 73 and 220 V.
// Configuration writes are taken at any edge with cfg_write high and are meant to happen
// while the block is idle.
`default_nettype none

module modbus_rtu_meter_poll_and_check (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             tx_valid,
    output logic [7:0]       tx_byte,
    output logic             tx_last,
    output logic             frame_valid,
    output logic             id_ok,
    output logic             crc_ok,
    output logic [31:0]      current_raw,
    output logic [40:0]      power_estimate,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Configuration registers.
    logic [7:0]  device_address_reg;
    logic [15:0] register_address_reg;
    logic [8:0]  line_voltage_reg;

    // Input register.
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_op_reg;
    logic [7:0]  s1_byte_reg;

    // Result register.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        tx_valid_reg;
    logic [7:0]  tx_byte_reg;
    logic        tx_last_reg;
    logic        frame_valid_reg;
    logic        id_ok_reg;
    logic        crc_ok_reg;
    logic [31:0] current_raw_reg;
    logic [40:0] power_estimate_reg;

    logic        out_free;
    logic        is_poll;
    logic        is_rx;
    logic        tx_step;
    logic        rx_step;
    logic        frame_emit;
    logic        s1_done;
    logic        accept;
    logic [7:0]  seq_byte;
    logic        seq_last;
    logic        rx_at_last;

    mbrtu_pkg::frame_report_t rx_report;

    mbrtu_tx_seq u_tx_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (tx_step),
        .device_address   (device_address_reg),
        .register_address (register_address_reg),
        .tx_byte          (seq_byte),
        .tx_last          (seq_last)
    );

    mbrtu_rx_deframer u_rx_deframer (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (rx_step),
        .rx_byte        (s1_byte_reg),
        .device_address (device_address_reg),
        .line_voltage   (line_voltage_reg),
        .at_last        (rx_at_last),
        .report         (rx_report)
    );

    // The result register can take a new transfer when empty or being drained this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    assign is_poll = s1_valid_reg && (s1_op_reg == mbrtu_pkg::OP_POLL);
    assign is_rx   = s1_valid_reg && (s1_op_reg == mbrtu_pkg::OP_RX_BYTE);

    // A poll emits one request byte per free output cycle. A received byte that does not
    // complete a frame needs no output slot and retires at once.
    assign tx_step    = is_poll && out_free;
    assign rx_step    = is_rx && (!rx_at_last || out_free);
    assign frame_emit = rx_step && rx_at_last;
    assign s1_done    = (tx_step && seq_last) || rx_step;

    assign in_stall = s1_valid_reg && !s1_done;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_done)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = tx_step || frame_emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg   <= mbrtu_pkg::DEVICE_ADDRESS_RST;
            register_address_reg <= mbrtu_pkg::REGISTER_ADDRESS_RST;
            line_voltage_reg     <= mbrtu_pkg::LINE_VOLTAGE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mbrtu_pkg::REG_DEVICE_ADDRESS:   device_address_reg   <= cfg_data[7:0];
                mbrtu_pkg::REG_REGISTER_ADDRESS: register_address_reg <= cfg_data;
                mbrtu_pkg::REG_LINE_VOLTAGE:     line_voltage_reg     <= cfg_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= operation;
            s1_byte_reg <= rx_byte;
        end
    end

    // Result payload: request bytes carry zero frame fields and frame reports zero tx fields.
    always_ff @(posedge clk)
    begin
        if (tx_step)
        begin
            tx_valid_reg       <= 1'b1;
            tx_byte_reg        <= seq_byte;
            tx_last_reg        <= seq_last;
            frame_valid_reg    <= 1'b0;
            id_ok_reg          <= 1'b0;
            crc_ok_reg         <= 1'b0;
            current_raw_reg    <= 32'd0;
            power_estimate_reg <= 41'd0;
        end
        else if (frame_emit)
        begin
            tx_valid_reg       <= 1'b0;
            tx_byte_reg        <= 8'd0;
            tx_last_reg        <= 1'b0;
            frame_valid_reg    <= 1'b1;
            id_ok_reg          <= rx_report.id_ok;
            crc_ok_reg         <= rx_report.crc_ok;
            current_raw_reg    <= rx_report.current_raw;
            power_estimate_reg <= rx_report.power_estimate;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tx_valid       = tx_valid_reg;
    assign tx_byte        = tx_byte_reg;
    assign tx_last        = tx_last_reg;
    assign frame_valid    = frame_valid_reg;
    assign id_ok          = id_ok_reg;
    assign crc_ok         = crc_ok_reg;
    assign current_raw    = current_raw_reg;
    assign power_estimate = power_estimate_reg;

endmodule

`default_nettype wire

>>> tb/modbus_rtu_meter_poll_and_check_test.sv
// Self-checking testbench for the Modbus RTU meter poll-and-check block.
// Depends on mbrtu_pkg and modbus_rtu_meter_poll_and_check, which needs mbrtu_tx_seq and mbrtu_rx_deframer.
// It drives polls and response bytes and checks every result transfer against a local predictor.

module modbus_rtu_meter_poll_and_check_test;
    import mbrtu_pkg::*;

    // Consecutive cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    // Cycles allowed after the last expected result for a byte still in the input register.
    localparam int DRAIN_CYCLES = 8;
    localparam int FRAME_LEN = 9;
    // Byte count field of a read response carrying one 32-bit value.
    localparam logic [7:0] BYTE_COUNT = 8'h04;

    // One result transfer of the block, field by field.
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        frame_valid;
        logic        id_ok;
        logic        crc_ok;
        logic [31:0] current_raw;
        logic [40:0] power_estimate;
    } meter_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        frame_valid;
    logic        id_ok;
    logic        crc_ok;
    logic [31:0] current_raw;
    logic [40:0] power_estimate;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Configuration as the predictor believes it to be.
    logic [7:0]  cfg_device   = DEVICE_ADDRESS_RST;
    logic [15:0] cfg_register = REGISTER_ADDRESS_RST;
    logic [8:0]  cfg_volts    = LINE_VOLTAGE_RST;

    // Predicted state of the response deframer.
    logic [3:0]  rx_pos          = POS_FIRST;
    logic [15:0] rx_crc          = CRC_INIT;
    logic [31:0] rx_value        = '0;
    logic        rx_id_match     = 1'b0;
    logic        rx_crc_lo_match = 1'b0;

    // Results predicted for accepted items and not yet seen on the output.
    meter_result_t pending_replies[$];

    // Idle rates in percent for the sending and the receiving side.
    int send_idle_pct = 18;
    int recv_idle_pct = 62;
    int error_count   = 0;
    int quiet_cycles  = 0;

    modbus_rtu_meter_poll_and_check i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tx_valid       (tx_valid),
        .tx_byte        (tx_byte),
        .tx_last        (tx_last),
        .frame_valid    (frame_valid),
        .id_ok          (id_ok),
        .crc_ok         (crc_ok),
        .current_raw    (current_raw),
        .power_estimate (power_estimate),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The receiving side decides its stall at each falling edge, so the block
    // sees a stable value at the next rising edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Reflected CRC-16 over one byte, shifting the low bit out first.
    function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        repeat (8)
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        return acc;
    endfunction

    // Works out what one accepted item produces and queues it. A poll yields
    // the eight request bytes and leaves the deframer alone; a received byte
    // advances the deframer and only the ninth byte of a frame yields a report.
    task automatic predict_meter_item(input logic op, input logic [7:0] b);
        meter_result_t r;
        logic [15:0]   crc;
        logic [7:0]    req [8];
        if (op == OP_POLL)
        begin
            req[0] = cfg_device;
            req[1] = FUNC_READ_HOLDING;
            req[2] = cfg_register[15:8];
            req[3] = cfg_register[7:0];
            req[4] = QUANTITY_HI;
            req[5] = QUANTITY_LO;
            crc = CRC_INIT;
            for (int i = 0; i < 6; i++)
                crc = modbus_crc_byte(crc, req[i]);
            req[6] = crc[7:0];
            req[7] = crc[15:8];
            for (int i = 0; i < 8; i++)
            begin
                r          = '0;
                r.tx_valid = 1'b1;
                r.tx_byte  = req[i];
                r.tx_last  = (i == 7);
                pending_replies.push_back(r);
            end
        end
        else
        begin
            // The first byte of a frame restarts the accumulators and latches the id check.
            if (rx_pos == POS_FIRST)
            begin
                rx_crc          = CRC_INIT;
                rx_value        = '0;
                rx_id_match     = (b == cfg_device);
                rx_crc_lo_match = 1'b0;
            end
            if (rx_pos <= POS_LAST_DATA)
            begin
                rx_crc = modbus_crc_byte(rx_crc, b);
                if (rx_pos >= POS_VALUE_LO)
                    rx_value = {rx_value[23:0], b};
                rx_pos = rx_pos + 4'd1;
            end
            else if (rx_pos == POS_CRC_LO)
            begin
                rx_crc_lo_match = (b == rx_crc[7:0]);
                rx_pos          = POS_CRC_HI;
            end
            else
            begin
                r                = '0;
                r.frame_valid    = 1'b1;
                r.id_ok          = rx_id_match;
                r.crc_ok         = rx_crc_lo_match && (b == rx_crc[15:8]);
                r.current_raw    = rx_value;
                r.power_estimate = {9'd0, rx_value} * {32'd0, cfg_volts};
                pending_replies.push_back(r);
                rx_pos = POS_FIRST;
                rx_crc = CRC_INIT;
            end
        end
    endtask

    // Offers one item and returns at the rising edge where it is transferred.
    // Valid is left high, so a following item without a gap keeps it high and
    // only the payload changes at the next falling edge.
    task automatic send_item(input logic op, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        rx_byte   <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_meter_item(op, b);
    endtask

    // Stops offering items and waits until every predicted result has arrived,
    // then lets a received byte that produces nothing drain out as well.
    task automatic wait_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Writes all three registers on consecutive cycles; the block must be idle.
    task automatic configure_meter(input logic [7:0] dev, input logic [15:0] reg_addr,
                                   input logic [8:0] volts);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_DEVICE_ADDRESS;
        cfg_data  <= {8'h00, dev};
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_REGISTER_ADDRESS;
        cfg_data  <= reg_addr;
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_LINE_VOLTAGE;
        cfg_data  <= {7'h00, volts};
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_device   = dev;
        cfg_register = reg_addr;
        cfg_volts    = volts;
    endtask

    // Sends one nine-byte read response. A nonnegative corrupt_at flips bits of
    // that byte after the CRC is computed; a nonnegative poll_at slips a poll in
    // just ahead of that byte.
    task automatic send_frame(input logic [7:0] id, input logic [31:0] value, input int corrupt_at,
                              input logic [7:0] corrupt_mask, input int poll_at);
        logic [7:0]  fb [FRAME_LEN];
        logic [15:0] crc;
        fb[0] = id;
        fb[1] = FUNC_READ_HOLDING;
        fb[2] = BYTE_COUNT;
        fb[3] = value[31:24];
        fb[4] = value[23:16];
        fb[5] = value[15:8];
        fb[6] = value[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < 7; i++)
            crc = modbus_crc_byte(crc, fb[i]);
        fb[7] = crc[7:0];
        fb[8] = crc[15:8];
        if (corrupt_at >= 0)
            fb[corrupt_at] = fb[corrupt_at] ^ corrupt_mask;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if (i == poll_at)
                send_item(OP_POLL, 8'($urandom));
            send_item(OP_RX_BYTE, fb[i]);
        end
    endtask

    // Mostly well-formed responses with random content, some damaged, plus
    // polls (a few of them inside a frame) and stray bytes that knock the
    // deframer out of step.
    task automatic run_random_phase(input int send_pct, input int recv_pct, input int item_target,
                                    input logic [7:0] dev, input logic [15:0] reg_addr,
                                    input logic [8:0] volts);
        int          sent;
        int          pick;
        int          corrupt_at;
        int          poll_at;
        logic [7:0]  id;
        logic [31:0] value;
        wait_until_drained();
        configure_meter(dev, reg_addr, volts);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < item_target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                send_item(OP_POLL, 8'($urandom));
                sent++;
                // Now and then the sender holds off until every request byte is out.
                if ($urandom_range(0, 99) < 15)
                    wait_until_drained();
            end
            else if (pick < 80)
            begin
                // Finish any partial frame with random bytes so the next one lines up.
                while (rx_pos != POS_FIRST)
                begin
                    send_item(OP_RX_BYTE, 8'($urandom));
                    sent++;
                end
                id = ($urandom_range(0, 99) < 85) ? cfg_device : 8'($urandom);
                case ($urandom_range(0, 9))
                    0:       value = 32'h0000_0000;
                    1:       value = 32'hFFFF_FFFF;
                    default: value = $urandom;
                endcase
                corrupt_at = ($urandom_range(0, 99) < 25) ? $urandom_range(0, FRAME_LEN - 1) : -1;
                poll_at    = ($urandom_range(0, 99) < 8) ? $urandom_range(1, FRAME_LEN - 1) : -1;
                send_frame(id, value, corrupt_at, 8'($urandom_range(1, 255)), poll_at);
                sent += FRAME_LEN + ((poll_at >= 0) ? 1 : 0);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_item(OP_RX_BYTE, 8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // A poll with the reset configuration, after which the sender pauses
    // until all eight request bytes have been transferred.
    task automatic test_default_poll();
        send_item(OP_POLL, 8'hA5);
        wait_until_drained();
    endtask

    // Top register values and a voltage above the nominal range, then a
    // correct frame carrying the largest current with a poll in its middle.
    task automatic test_max_frame_with_poll();
        wait_until_drained();
        configure_meter(8'hFF, 16'hFFFF, 9'd511);
        send_frame(8'hFF, 32'hFFFF_FFFF, -1, 8'h00, 4);
    endtask

    // All registers at zero, then a frame with the wrong id and a bad CRC high
    // byte, and a poll that carries register zero.
    task automatic test_faulty_frame();
        wait_until_drained();
        configure_meter(8'h00, 16'h0000, 9'd0);
        send_frame(8'h80, 32'h0000_0000, FRAME_LEN - 1, 8'h01, -1);
        send_item(OP_POLL, 8'h00);
    endtask

    task automatic test_random_slow_receiver();
        run_random_phase(18, 62, 105, 8'($urandom), 16'($urandom), 9'($urandom_range(1, 400)));
    endtask

    task automatic test_random_slow_sender();
        run_random_phase(62, 18, 105, 8'($urandom), 16'($urandom), 9'd400);
    endtask

    task automatic test_random_full_rate();
        run_random_phase(0, 0, 105, 8'($urandom), 16'($urandom), 9'($urandom_range(0, 400)));
    endtask

    task automatic compare_field(input string name, input logic [40:0] want, input logic [40:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Every result transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        meter_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: result transfer with none pending, expected none, actual tx %0h frame %0h",
                         $time, tx_byte, current_raw);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                compare_field("tx_valid", want.tx_valid, tx_valid);
                compare_field("tx_byte", want.tx_byte, tx_byte);
                compare_field("tx_last", want.tx_last, tx_last);
                compare_field("frame_valid", want.frame_valid, frame_valid);
                compare_field("id_ok", want.id_ok, id_ok);
                compare_field("crc_ok", want.crc_ok, crc_ok);
                compare_field("current_raw", want.current_raw, current_raw);
                compare_field("power_estimate", want.power_estimate, power_estimate);
            end
        end
    end

    // A hung handshake shows up as a long run of cycles with no transfer on
    // either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = OP_RX_BYTE;
        rx_byte   = 8'h00;
        cfg_write = 1'b0;
        cfg_index = REG_DEVICE_ADDRESS;
        cfg_data  = 16'h0000;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_poll();
        test_max_frame_with_poll();
        test_faulty_frame();
        test_random_slow_receiver();
        test_random_slow_sender();
        test_random_full_rate();

        wait_until_drained();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
